// ===== rtl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the allocation size tracker: payload
// words, table entry layout, scan result flags, command and status codes.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int AST_TABLE_ENTRIES = 64;
  localparam int AST_DATA_W        = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_REALLOC = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_DRAIN   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [AST_DATA_W-1:0] addr;
    logic [AST_DATA_W-1:0] size;
    logic [AST_DATA_W-1:0] prev_addr;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [AST_DATA_W-1:0] sample_total;
    logic [AST_DATA_W-1:0] total_after;
    logic [AST_DATA_W-1:0] old_size;
    logic [AST_DATA_W-1:0] leaked_addr;
  } out_word_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic                  vld;
    logic [AST_DATA_W-1:0] addr;
    logic [AST_DATA_W-1:0] size;
  } tbl_word_t;

  // what a table scan found
  typedef struct packed {
    logic hit_p;     // key entry found
    logic hit_a;     // target address already present
    logic ff_found;  // some free slot seen
    logic fv_found;  // some live slot seen
  } scan_flags_t;

endpackage

// ===== rtl/allocation_size_tracker_top.sv =====
// ----------------------------------------------------------------------------
// allocation_size_tracker_top
// Bounded table of live allocations with a running byte total. Each event
// scans the table once, then one shared adder and a short write sequence
// finish it.
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  in_word_t  (cmd, addr, size, prev_addr)
//   out_     out  out_valid/out_stall out_word_t (status, totals, sizes)
//
// A word is taken only once the previous one has been handed to the output
// register. Each word runs a scan of the single read port table RAM, two
// adder steps, two write steps and the handoff to the output register;
// in_stall is high from when the word is taken until that handoff.
// After reset a clearing pass over every table entry runs with in_stall high.
// A finished word waits in the output register; the next word can be taken
// and scanned while it waits.
// ----------------------------------------------------------------------------
module allocation_size_tracker_top #(
  parameter int TABLE_ENTRIES = ast_pkg::AST_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ast_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ast_pkg::out_word_t out_data
);
  import ast_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_ALU1  = 7'b0001000,
    S_ALU2  = 7'b0010000,
    S_WR1   = 7'b0100000,
    S_WR2   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic        done_r, done_nxt;
  in_word_t    in_r;
  logic [63:0] total_r, s1_r, s2_r;
  logic        out_valid_r;
  out_word_t   out_r;

  // table RAM ports
  logic        mem_we, mem_re;
  logic [IW-1:0] mem_wa;
  tbl_word_t   mem_wd, rd_data;

  // scan results
  scan_flags_t flags;
  logic [IW-1:0] idx_p, ff_idx, fv_idx, slot;
  logic [63:0] size_p, fv_addr, fv_size, key_p;

  logic is_alloc, is_realloc, is_free, hit, inplace, move;
  logic accept, scan_start, load_out;

  // shared adder
  logic [63:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  status_t     res_status;
  logic [63:0] res_total, res_sample, res_old, res_leaked;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE) || done_r;
  assign scan_start = accept;

  assign is_alloc   = (in_r.cmd == CMD_ALLOC);
  assign is_realloc = (in_r.cmd == CMD_REALLOC);
  assign is_free    = (in_r.cmd == CMD_FREE);
  assign hit        = flags.hit_p;
  assign inplace    = is_realloc && hit && (in_r.prev_addr == in_r.addr);
  assign move       = is_realloc && hit && (in_r.prev_addr != in_r.addr);
  assign key_p      = is_realloc ? in_r.prev_addr : in_r.addr;

  // lowest free slot once the moved entry's own slot is released
  assign slot = (flags.ff_found && (ff_idx < idx_p)) ? ff_idx : idx_p;

  assign mem_re = (state_r == S_SCAN) && (cnt_r != CW'(TABLE_ENTRIES));

  ast_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IW    (IW)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .wa        (mem_wa),
    .wd        (mem_wd),
    .re        (mem_re),
    .ra        (cnt_r[IW-1:0]),
    .rd_data_r (rd_data)
  );

  ast_scan #(
    .IW (IW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .en        (rd_vld_r),
    .idx       (rd_idx_r),
    .word      (rd_data),
    .key_p     (key_p),
    .key_a     (in_r.addr),
    .flags_r   (flags),
    .idx_p_r   (idx_p),
    .ff_idx_r  (ff_idx),
    .fv_idx_r  (fv_idx),
    .size_p_r  (size_p),
    .fv_addr_r (fv_addr),
    .fv_size_r (fv_size)
  );

  // first step: total +/- one operand, second step: that sum +/- the other
  always_comb begin
    alu_a   = total_r;
    alu_b   = in_r.size;
    alu_sub = 1'b0;
    if (state_r == S_ALU2) begin
      alu_a   = s1_r;
      alu_b   = move ? size_p : in_r.size;
      alu_sub = move;
    end else if (is_free || inplace) begin
      alu_b   = size_p;
      alu_sub = 1'b1;
    end
  end

  assign alu_y = alu_a + (alu_b ^ {64{alu_sub}}) + 64'(alu_sub);

  // table writes: clearing pass, then primary and secondary event writes
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_p;
    mem_wd = '{vld: 1'b0, addr: in_r.addr, size: in_r.size};
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[IW-1:0];
      end
      S_WR1: begin
        if (is_alloc) begin
          mem_we     = !hit && flags.ff_found;
          mem_wa     = ff_idx;
          mem_wd.vld = 1'b1;
        end else if (inplace) begin
          mem_we      = 1'b1;
          mem_wd.vld  = 1'b1;
          mem_wd.addr = in_r.prev_addr;
        end else if (is_realloc || is_free) begin
          mem_we = hit;
        end else begin
          mem_we = flags.fv_found;
          mem_wa = fv_idx;
        end
      end
      S_WR2: begin
        mem_we     = move && !flags.hit_a;
        mem_wa     = slot;
        mem_wd.vld = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_status = ST_OK;
    res_total  = total_r;
    res_sample = total_r;
    res_old    = '0;
    res_leaked = '0;
    unique case (in_r.cmd)
      CMD_ALLOC: begin
        res_total  = s1_r;
        res_sample = s1_r;
        if (hit) begin
          res_status = ST_DUPLICATE;
        end else if (!flags.ff_found) begin
          res_status = ST_FULL;
        end
      end
      CMD_REALLOC: begin
        if (!hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_old    = size_p;
          res_total  = s2_r;
          res_sample = inplace ? s2_r : s1_r;
          if (move && flags.hit_a) begin
            res_status = ST_DUPLICATE;
          end
        end
      end
      CMD_FREE: begin
        if (!hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_old    = size_p;
          res_total  = s1_r;
          res_sample = s1_r;
        end
      end
      CMD_DRAIN: begin
        if (!flags.fv_found) begin
          res_status = ST_EMPTY;
        end else begin
          res_old    = fv_size;
          res_leaked = fv_addr;
        end
      end
      default: ;
    endcase
  end

  assign load_out = done_r && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (load_out) done_nxt = 1'b0;
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mem_re) begin
          cnt_nxt = cnt_r + CW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_ALU1;
        end
      end
      S_ALU1: state_nxt = S_ALU2;
      S_ALU2: state_nxt = S_WR1;
      S_WR1:  state_nxt = S_WR2;
      S_WR2: begin
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      done_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= mem_re;
      done_r   <= done_nxt;
      if (load_out) begin
        total_r     <= res_total;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IW-1:0];
    if (accept) in_r <= in_data;
    if (state_r == S_ALU1) s1_r <= alu_y;
    if (state_r == S_ALU2) s2_r <= alu_y;
    if (load_out) begin
      out_r <= '{status:       res_status,
                 sample_total: res_sample,
                 total_after:  res_total,
                 old_size:     res_old,
                 leaked_addr:  res_leaked};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("scan did not start at entry zero");

  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALU1) |-> $past(state_r == S_SCAN) && ($past(cnt_r) == CW'(TABLE_ENTRIES)))
    else $error("scan left before covering the table");

  a_move_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR2) && mem_we |-> move && (slot <= idx_p))
    else $error("moved entry placed above the released slot");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_r))
    else $error("result word without a finished event");

endmodule

// ===== rtl/ast_mem.sv =====
// ----------------------------------------------------------------------------
// ast_mem
// Allocation table RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ast_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     wa,
  input  ast_pkg::tbl_word_t wd,
  input  logic              re,
  input  logic [IW-1:0]     ra,
  output ast_pkg::tbl_word_t rd_data_r
);
  import ast_pkg::*;

  tbl_word_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem_r[ra];
    end
  end

endmodule

// ===== rtl/ast_scan.sv =====
// ----------------------------------------------------------------------------
// ast_scan
// Compare unit walked over the table one entry per cycle. Keeps the first
// key match, first target match, first free slot and first live slot.
// ----------------------------------------------------------------------------
module ast_scan #(
  parameter int IW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 en,
  input  logic [IW-1:0]        idx,
  input  ast_pkg::tbl_word_t   word,
  input  logic [63:0]          key_p,
  input  logic [63:0]          key_a,
  output ast_pkg::scan_flags_t flags_r,
  output logic [IW-1:0]        idx_p_r,
  output logic [IW-1:0]        ff_idx_r,
  output logic [IW-1:0]        fv_idx_r,
  output logic [63:0]          size_p_r,
  output logic [63:0]          fv_addr_r,
  output logic [63:0]          fv_size_r
);
  import ast_pkg::*;

  logic take_p, take_a, take_ff, take_fv;

  assign take_p  = en && word.vld && (word.addr == key_p) && !flags_r.hit_p;
  assign take_a  = en && word.vld && (word.addr == key_a) && !flags_r.hit_a;
  assign take_ff = en && !word.vld && !flags_r.ff_found;
  assign take_fv = en && word.vld && !flags_r.fv_found;

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      flags_r <= '0;
    end else begin
      if (take_p)  flags_r.hit_p    <= 1'b1;
      if (take_a)  flags_r.hit_a    <= 1'b1;
      if (take_ff) flags_r.ff_found <= 1'b1;
      if (take_fv) flags_r.fv_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_p) begin
      idx_p_r  <= idx;
      size_p_r <= word.size;
    end
    if (take_ff) begin
      ff_idx_r <= idx;
    end
    if (take_fv) begin
      fv_idx_r  <= idx;
      fv_addr_r <= word.addr;
      fv_size_r <= word.size;
    end
  end

endmodule
